// ----- hw/rtl/olrs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olrs_pkg
// Shared types, widths and helpers for the overwriting log ring.
// ----------------------------------------------------------------------------
package olrs_pkg;

	localparam int RING_DEPTH   = 32;
	localparam int PAYLOAD_BITS = 32;
	localparam int IDX_W        = $clog2(RING_DEPTH);
	localparam int CNT_W        = $clog2(RING_DEPTH + 1);
	localparam int CFG_W        = 6;
	localparam int MAXE_W       = 6;
	localparam int CMP_W        = (CNT_W > MAXE_W) ? CNT_W : MAXE_W;
	localparam int PAY_W        = 32;
	localparam int SEQ_W        = 32;
	localparam int WRITER_W     = 16;
	localparam int TIME_W       = 64;

	// command queue between front and back
	localparam int CQ_DEPTH = 4;
	localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_ENTRY = 2'd1,
		ST_EMPTY = 2'd2,
		ST_BAD   = 2'd3
	} status_t;

	typedef enum logic {
		OP_APPEND   = 1'b0,
		OP_SNAPSHOT = 1'b1
	} op_t;

	typedef struct packed {
		logic [PAYLOAD_BITS-1:0] payload;
		logic [SEQ_W-1:0]        sequence_num;
		logic [WRITER_W-1:0]     writer;
		logic [TIME_W-1:0]       stamp;
	} entry_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} mem_wr_t;

	typedef struct packed {
		status_t          kind;
		logic [IDX_W-1:0] start;
		logic [CNT_W-1:0] count;
	} cmd_t;

	// Map a written capacity onto 1..RING_DEPTH
	function automatic logic [CNT_W-1:0] clamp_capacity(input logic [CFG_W-1:0] v);
		logic [CMP_W:0] vx;
		logic [CNT_W-1:0] r;
		vx = (CMP_W + 1)'(v);
		if (v == '0)
			r = CNT_W'(1);
		else if (vx > (CMP_W + 1)'(RING_DEPTH))
			r = CNT_W'(RING_DEPTH);
		else
			r = CNT_W'(v);
		return r;
	endfunction

	// Step a ring index, wrapping at the capacity in use
	function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx,
	                                                input logic [CNT_W-1:0] cap);
		logic [CNT_W:0] inc;
		logic [IDX_W-1:0] r;
		inc = (CNT_W + 1)'(idx) + (CNT_W + 1)'(1);
		if (inc >= (CNT_W + 1)'(cap))
			r = '0;
		else
			r = inc[IDX_W-1:0];
		return r;
	endfunction

endpackage

// ----- hw/rtl/olrs_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olrs_front
// Accepts input beats, keeps the ring pointers and sequence counter, writes
// appended entries and posts one command per beat to the back end.
// ----------------------------------------------------------------------------
module olrs_front import olrs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [CFG_W-1:0]    cfg_wr_data,
	input  logic                push,
	output logic                full,
	input  logic                operation,
	input  logic [PAY_W-1:0]    entry_payload,
	input  logic [WRITER_W-1:0] writer_id,
	input  logic [TIME_W-1:0]   time_stamp,
	input  logic [MAXE_W-1:0]   entry_limit,
	input  logic                q_full,
	output logic                q_push,
	output cmd_t                q_wdata,
	output mem_wr_t             mem_wr,
	output logic [CNT_W-1:0]    capacity,
	input  logic                snap_done
);

	logic [CNT_W-1:0] cap_q;
	logic [IDX_W-1:0] wp_q;
	logic [IDX_W-1:0] oldest_q;
	logic [CNT_W-1:0] fill_q;
	logic [SEQ_W-1:0] seq_q;
	logic             snap_pend_q;
	logic             accept;
	logic             is_append;
	logic [CMP_W-1:0] want_x;
	logic [CMP_W-1:0] fill_x;
	logic [CNT_W-1:0] take;

	// Hold input while the queue is full or a snapshot still reads the ring
	assign full      = q_full | snap_pend_q;
	assign accept    = push & ~full;
	assign is_append = (op_t'(operation) == OP_APPEND);
	assign capacity  = cap_q;

	// Size the snapshot
	assign want_x = CMP_W'(entry_limit);
	assign fill_x = CMP_W'(fill_q);
	assign take   = (want_x < fill_x) ? CNT_W'(entry_limit) : fill_q;

	// Classify the beat into a back-end command
	always_comb begin
		q_wdata.kind  = ST_DONE;
		q_wdata.start = oldest_q;
		q_wdata.count = take;
		if (!is_append) begin
			if (entry_limit == '0)
				q_wdata.kind = ST_BAD;
			else if (fill_q == '0)
				q_wdata.kind = ST_EMPTY;
			else
				q_wdata.kind = ST_ENTRY;
		end
	end
	assign q_push = accept;

	// Write port for appends
	always_comb begin
		mem_wr.en                = accept & is_append;
		mem_wr.addr              = wp_q;
		mem_wr.data.payload      = entry_payload[PAYLOAD_BITS-1:0];
		mem_wr.data.sequence_num = seq_q;
		mem_wr.data.writer       = writer_id;
		mem_wr.data.stamp        = time_stamp;
	end

	// Advance the ring state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CNT_W'(RING_DEPTH);
			wp_q        <= '0;
			oldest_q    <= '0;
			fill_q      <= '0;
			seq_q       <= '0;
			snap_pend_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cap_q    <= clamp_capacity(cfg_wr_data);
				wp_q     <= '0;
				oldest_q <= '0;
				fill_q   <= '0;
			end else if (accept && is_append) begin
				wp_q  <= next_index(wp_q, cap_q);
				seq_q <= seq_q + SEQ_W'(1);
				if (fill_q < cap_q)
					fill_q <= fill_q + CNT_W'(1);
				else
					oldest_q <= next_index(oldest_q, cap_q);
			end
			if (accept && (q_wdata.kind == ST_ENTRY))
				snap_pend_q <= 1'b1;
			else if (snap_done)
				snap_pend_q <= 1'b0;
		end
	end

endmodule

// ----- hw/rtl/olrs_cmdq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olrs_cmdq
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module olrs_cmdq import olrs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic q_push,
	input  cmd_t q_wdata,
	output logic q_full,
	input  logic q_pop,
	output cmd_t q_head,
	output logic q_empty
);

	cmd_t                slot_q [CQ_DEPTH];
	logic [CQ_PTR_W-1:0] wr_ptr_q;
	logic [CQ_PTR_W-1:0] rd_ptr_q;
	logic [CQ_CNT_W-1:0] cnt_q;
	logic                do_push;
	logic                do_pop;

	assign q_full  = (cnt_q == CQ_CNT_W'(CQ_DEPTH));
	assign q_empty = (cnt_q == '0);
	assign q_head  = slot_q[rd_ptr_q];
	assign do_push = q_push & ~q_full;
	assign do_pop  = q_pop & ~q_empty;

	// Store a beat
	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= q_wdata;
	end

	// Move pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + CQ_PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + CQ_PTR_W'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CQ_CNT_W'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CQ_CNT_W'(1);
		end
	end

endmodule

// ----- hw/rtl/olrs_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olrs_back
// Holds the entry memory, walks snapshot commands one entry per beat and
// drives the registered result stage.
// ----------------------------------------------------------------------------
module olrs_back import olrs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  mem_wr_t             mem_wr,
	input  logic [CNT_W-1:0]    capacity,
	input  cmd_t                q_head,
	input  logic                q_empty,
	output logic                q_pop,
	output logic                snap_done,
	output logic                empty,
	input  logic                pop,
	output logic [1:0]          status,
	output logic [PAY_W-1:0]    out_payload,
	output logic [SEQ_W-1:0]    out_sequence,
	output logic [WRITER_W-1:0] out_writer,
	output logic [TIME_W-1:0]   out_time,
	output logic                last
);

	entry_t           mem [RING_DEPTH];
	entry_t           rd_q;
	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] remain_q;
	logic             out_valid_q;
	status_t          out_status_q;
	logic             out_last_q;
	logic             beat_valid;
	status_t          beat_status;
	logic [IDX_W-1:0] beat_idx;
	logic             beat_last;
	logic             advance;
	logic             has_entry;

	// Pick the next result beat: an ongoing walk first, else the queue head
	always_comb begin
		beat_valid  = 1'b0;
		beat_status = ST_ENTRY;
		beat_idx    = idx_q;
		beat_last   = (remain_q == CNT_W'(1));
		if (busy_q) begin
			beat_valid = 1'b1;
		end else if (!q_empty) begin
			beat_valid  = 1'b1;
			beat_status = q_head.kind;
			beat_idx    = q_head.start;
			beat_last   = (q_head.kind != ST_ENTRY) || (q_head.count == CNT_W'(1));
		end
	end

	assign advance   = beat_valid & (~out_valid_q | pop);
	assign q_pop     = advance & ~busy_q;
	assign snap_done = advance & (beat_status == ST_ENTRY) & beat_last;

	// Walk the ring for multi-entry snapshots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			idx_q    <= '0;
			remain_q <= '0;
		end else if (advance) begin
			if (busy_q) begin
				if (beat_last)
					busy_q <= 1'b0;
				else begin
					idx_q    <= next_index(idx_q, capacity);
					remain_q <= remain_q - CNT_W'(1);
				end
			end else if ((q_head.kind == ST_ENTRY) && (q_head.count != CNT_W'(1))) begin
				busy_q   <= 1'b1;
				idx_q    <= next_index(q_head.start, capacity);
				remain_q <= q_head.count - CNT_W'(1);
			end
		end
	end

	// Entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_wr.en)
			mem[mem_wr.addr] <= mem_wr.data;
		if (advance)
			rd_q <= mem[beat_idx];
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (pop)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_status_q <= beat_status;
			out_last_q   <= beat_last;
		end
	end

	// Drive result ports; entry fields read as zero unless an entry is returned
	assign has_entry    = (out_status_q == ST_ENTRY);
	assign empty        = ~out_valid_q;
	assign status       = out_status_q;
	assign last         = out_last_q;
	assign out_payload  = has_entry ? PAY_W'(rd_q.payload) : '0;
	assign out_sequence = has_entry ? rd_q.sequence_num : '0;
	assign out_writer   = has_entry ? rd_q.writer : '0;
	assign out_time     = has_entry ? rd_q.stamp : '0;

endmodule

// ----- hw/rtl/overwriting_log_ring_snapshot_top.sv -----
`timescale 1ns / 1ps
// Path: an accepted input beat passes the command queue, then the result register.
// Throughput, while full is low and results are popped: appends and single-result
// requests go at one beat per cycle; a snapshot of n entries streams n results at
// one per cycle, one memory read each, and new input is held off until its last entry is read.
// Reset: arst_n clears pointers, fill, sequence, queues; capacity returns to 32.
// ----------------------------------------------------------------------------
// overwriting_log_ring_snapshot_top
// Log ring that overwrites its oldest entry when full and answers snapshot
// requests with the oldest stored entries in order.
// ----------------------------------------------------------------------------
module overwriting_log_ring_snapshot_top import olrs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [CFG_W-1:0]    cfg_wr_data,
	input  logic                push,
	output logic                full,
	input  logic                operation,
	input  logic [PAY_W-1:0]    entry_payload,
	input  logic [WRITER_W-1:0] writer_id,
	input  logic [TIME_W-1:0]   time_stamp,
	input  logic [MAXE_W-1:0]   entry_limit,
	output logic                empty,
	input  logic                pop,
	output logic [1:0]          status,
	output logic [PAY_W-1:0]    out_payload,
	output logic [SEQ_W-1:0]    out_sequence,
	output logic [WRITER_W-1:0] out_writer,
	output logic [TIME_W-1:0]   out_time,
	output logic                last
);

	logic             q_push;
	logic             q_full;
	logic             q_pop;
	logic             q_empty;
	cmd_t             q_wdata;
	cmd_t             q_head;
	mem_wr_t          mem_wr;
	logic [CNT_W-1:0] capacity;
	logic             snap_done;

	olrs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.push          (push),
		.full          (full),
		.operation     (operation),
		.entry_payload (entry_payload),
		.writer_id     (writer_id),
		.time_stamp    (time_stamp),
		.entry_limit   (entry_limit),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_wdata       (q_wdata),
		.mem_wr        (mem_wr),
		.capacity      (capacity),
		.snap_done     (snap_done)
	);

	olrs_cmdq u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_push  (q_push),
		.q_wdata (q_wdata),
		.q_full  (q_full),
		.q_pop   (q_pop),
		.q_head  (q_head),
		.q_empty (q_empty)
	);

	olrs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.mem_wr       (mem_wr),
		.capacity     (capacity),
		.q_head       (q_head),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.snap_done    (snap_done),
		.empty        (empty),
		.pop          (pop),
		.status       (status),
		.out_payload  (out_payload),
		.out_sequence (out_sequence),
		.out_writer   (out_writer),
		.out_time     (out_time),
		.last         (last)
	);

endmodule

// ----- tb/overwriting_log_ring_snapshot_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwriting_log_ring_snapshot_top_test
// Self-checking bench for the overwriting log ring. A driver pushes append and
// snapshot beats in random bursts, a monitor predicts every reply from a local
// copy of the ring and compares each popped reply field by field. The ring
// capacity is rewritten between phases, while the block is idle.
// ----------------------------------------------------------------------------
module overwriting_log_ring_snapshot_top_test import olrs_pkg::*; ;

	localparam int QUIET_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 8;

	typedef struct {
		op_t                 op;
		logic [PAY_W-1:0]    payload;
		logic [WRITER_W-1:0] writer;
		logic [TIME_W-1:0]   stamp;
		logic [MAXE_W-1:0]   max_count;
		bit                  wait_drained;
	} log_item_t;

	typedef struct {
		status_t             kind;
		logic [PAY_W-1:0]    payload;
		logic [SEQ_W-1:0]    seq_num;
		logic [WRITER_W-1:0] writer;
		logic [TIME_W-1:0]   stamp;
		logic                fin;
	} log_reply_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [CFG_W-1:0]    cfg_wr_data = '0;
	logic                push = 1'b0;
	logic                full;
	logic                operation = 1'b0;
	logic [PAY_W-1:0]    entry_payload = '0;
	logic [WRITER_W-1:0] writer_id = '0;
	logic [TIME_W-1:0]   time_stamp = '0;
	logic [MAXE_W-1:0]   entry_limit = '0;
	logic                empty;
	logic                pop = 1'b0;
	logic [1:0]          status;
	logic [PAY_W-1:0]    out_payload;
	logic [SEQ_W-1:0]    out_sequence;
	logic [WRITER_W-1:0] out_writer;
	logic [TIME_W-1:0]   out_time;
	logic                last;

	overwriting_log_ring_snapshot_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.push         (push),
		.full         (full),
		.operation    (operation),
		.entry_payload(entry_payload),
		.writer_id    (writer_id),
		.time_stamp   (time_stamp),
		.entry_limit  (entry_limit),
		.empty        (empty),
		.pop          (pop),
		.status       (status),
		.out_payload  (out_payload),
		.out_sequence (out_sequence),
		.out_writer   (out_writer),
		.out_time     (out_time),
		.last         (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Local copy of the ring
	entry_t      ring_copy[RING_DEPTH];
	int          ring_cap = RING_DEPTH;
	int          ring_wr = 0;
	int          ring_oldest = 0;
	int          ring_fill = 0;
	logic [31:0] seq_next = '0;

	log_item_t  items_to_send[$];
	log_reply_t replies_due[$];

	bit took_in = 1'b0;
	bit took_out = 1'b0;
	int quiet_cycles = 0;
	int n_errors = 0;
	int n_appends = 0;
	int n_snapshots = 0;
	int n_overwrites = 0;
	int n_replies = 0;
	int n_settings = 1;

	function automatic int capacity_of(logic [CFG_W-1:0] v);
		if (v == '0)
			return 1;
		if (int'(v) > RING_DEPTH)
			return RING_DEPTH;
		return int'(v);
	endfunction

	function automatic log_reply_t plain_reply(status_t kind);
		log_reply_t r;
		r = '{kind: kind, payload: '0, seq_num: '0, writer: '0, stamp: '0, fin: 1'b1};
		return r;
	endfunction

	// Work out the replies for one accepted beat and queue them
	task automatic predict_log_beat(log_item_t it);
		log_reply_t r;
		int         count;
		int         idx;
		if (it.op == OP_APPEND) begin
			ring_copy[ring_wr].payload = it.payload;
			ring_copy[ring_wr].sequence_num = seq_next;
			ring_copy[ring_wr].writer = it.writer;
			ring_copy[ring_wr].stamp = it.stamp;
			seq_next = seq_next + 1;
			ring_wr = (ring_wr + 1) % ring_cap;
			if (ring_fill < ring_cap) begin
				ring_fill++;
			end else begin
				ring_oldest = (ring_oldest + 1) % ring_cap;
				n_overwrites++;
			end
			replies_due.push_back(plain_reply(ST_DONE));
			n_appends++;
		end else begin
			n_snapshots++;
			if (it.max_count == '0) begin
				replies_due.push_back(plain_reply(ST_BAD));
			end else if (ring_fill == 0) begin
				replies_due.push_back(plain_reply(ST_EMPTY));
			end else begin
				count = (int'(it.max_count) < ring_fill) ? int'(it.max_count) : ring_fill;
				for (int i = 0; i < count; i++) begin
					idx = (ring_oldest + i) % ring_cap;
					r.kind = ST_ENTRY;
					r.payload = ring_copy[idx].payload;
					r.seq_num = ring_copy[idx].sequence_num;
					r.writer = ring_copy[idx].writer;
					r.stamp = ring_copy[idx].stamp;
					r.fin = (i == count - 1);
					replies_due.push_back(r);
				end
			end
		end
	endtask

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			n_errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	// Sample both handshakes and the register write, check replies, run the watchdog
	always @(posedge clk) begin
		log_reply_t want;
		log_item_t  seen;
		took_in = arst_n && push && !full;
		took_out = arst_n && pop && !empty;
		if (took_out) begin
			n_replies++;
			if (replies_due.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected reply, expected none, actual status %0d", $time, status);
			end else begin
				want = replies_due.pop_front();
				check_field("status", 64'(want.kind), 64'(status));
				check_field("out_payload", 64'(want.payload), 64'(out_payload));
				check_field("out_sequence", 64'(want.seq_num), 64'(out_sequence));
				check_field("out_writer", 64'(want.writer), 64'(out_writer));
				check_field("out_time", want.stamp, out_time);
				check_field("last", 64'(want.fin), 64'(last));
			end
		end
		if (took_in) begin
			seen.op = op_t'(operation);
			seen.payload = entry_payload;
			seen.writer = writer_id;
			seen.stamp = time_stamp;
			seen.max_count = entry_limit;
			seen.wait_drained = 1'b0;
			predict_log_beat(seen);
		end
		if (arst_n && cfg_wr_en) begin
			ring_cap = capacity_of(cfg_wr_data);
			ring_wr = 0;
			ring_oldest = 0;
			ring_fill = 0;
		end
		if (took_in || took_out || cfg_wr_en || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	// Drive input beats in bursts; hold a beat until it is taken
	int        gap_left = 0;
	int        burst_left = 1;
	bit        next_push;
	log_item_t cur_item;

	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (push && !took_in) begin
			// hold the current beat
		end else begin
			next_push = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (items_to_send.size() > 0 &&
			             !(items_to_send[0].wait_drained && replies_due.size() != 0)) begin
				cur_item = items_to_send.pop_front();
				operation <= cur_item.op;
				entry_payload <= cur_item.payload;
				writer_id <= cur_item.writer;
				time_stamp <= cur_item.stamp;
				entry_limit <= cur_item.max_count;
				next_push = 1'b1;
				if (burst_left <= 1) begin
					burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
					                                         : $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end
			push <= next_push;
		end
	end

	// Receiver stalls: pop follows one of four randomly drawn modes
	int pop_mode = 0;
	int pop_tick = 0;

	always @(negedge clk) begin
		if (pop_tick % 40 == 0)
			pop_mode = $urandom_range(0, 3);
		pop_tick++;
		case (pop_mode)
			0: pop <= 1'b1;
			1: pop <= 1'($urandom_range(0, 1));
			2: pop <= ($urandom_range(0, 3) == 0);
			default: pop <= (pop_tick % 8 < 3);
		endcase
	end

	function automatic log_item_t make_item(op_t op, logic [PAY_W-1:0] payload,
	                                        logic [WRITER_W-1:0] writer,
	                                        logic [TIME_W-1:0] stamp,
	                                        logic [MAXE_W-1:0] max_count, bit wait_drained);
		log_item_t it;
		it = '{op: op, payload: payload, writer: writer, stamp: stamp,
		       max_count: max_count, wait_drained: wait_drained};
		return it;
	endfunction

	function automatic log_item_t random_item(bit force_snapshot);
		log_item_t it;
		int        pick;
		it.op = (force_snapshot || $urandom_range(0, 99) < 35) ? OP_SNAPSHOT : OP_APPEND;
		it.payload = $urandom;
		it.writer = WRITER_W'($urandom);
		it.stamp = {$urandom, $urandom};
		pick = $urandom_range(0, 99);
		if (pick < 10)
			it.max_count = '0;
		else if (pick < 55)
			it.max_count = MAXE_W'($urandom_range(1, 8));
		else if (pick < 85)
			it.max_count = MAXE_W'($urandom_range(9, 32));
		else
			it.max_count = MAXE_W'($urandom_range(33, 63));
		it.wait_drained = ($urandom_range(0, 99) < 4);
		return it;
	endfunction

	task automatic add_appends(int n);
		for (int i = 0; i < n; i++)
			items_to_send.push_back(make_item(OP_APPEND, $urandom, WRITER_W'($urandom),
			                                  {$urandom, $urandom}, MAXE_W'($urandom),
			                                  1'b0));
	endtask

	task automatic add_snapshot(logic [MAXE_W-1:0] max_count, bit wait_drained);
		items_to_send.push_back(make_item(OP_SNAPSHOT, $urandom, WRITER_W'($urandom),
		                                  {$urandom, $urandom}, max_count, wait_drained));
	endtask

	// Wait until every beat is sent and every reply is back, then let the pipe settle
	task automatic wait_drained;
		do
			@(negedge clk);
		while (items_to_send.size() != 0 || push || replies_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_capacity(logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		n_settings++;
	endtask

	logic [CFG_W-1:0] random_caps[6];

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset capacity: errors and empty log first, then field extremes
		add_snapshot('0, 1'b0);
		add_snapshot(6'd7, 1'b0);
		items_to_send.push_back(make_item(OP_APPEND, '0, '0, '0, '0, 1'b0));
		items_to_send.push_back(make_item(OP_APPEND, '1, '1, '1, '1, 1'b0));
		add_appends(1);
		add_snapshot('0, 1'b0);
		add_snapshot(6'd1, 1'b0);
		add_snapshot('1, 1'b0);
		add_snapshot(6'd32, 1'b1);
		wait_drained();

		// Two entries: wrap and overwrite the oldest
		write_capacity(6'd2);
		add_appends(4);
		add_snapshot(6'd2, 1'b0);
		add_snapshot('1, 1'b0);
		wait_drained();

		// Zero capacity acts as one entry
		write_capacity('0);
		add_appends(2);
		add_snapshot(6'd1, 1'b0);
		add_snapshot(6'd5, 1'b0);
		wait_drained();

		// Random phases; each opens with a snapshot of the freshly emptied log
		random_caps = '{6'd63, 6'd1, 6'd5, 6'd32, 6'($urandom_range(2, 31)), 6'd17};
		foreach (random_caps[p]) begin
			write_capacity(random_caps[p]);
			items_to_send.push_back(random_item(1'b1));
			for (int i = 0; i < 26; i++)
				items_to_send.push_back(random_item(1'b0));
			wait_drained();
		end

		$display("Covered %0d appends (%0d overwrites) and %0d snapshots, %0d replies checked",
		         n_appends, n_overwrites, n_snapshots, n_replies);
		$display("over %0d capacity settings, among them 0, 1, 2, 32 and 63", n_settings);
		if (n_errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/olrs_pkg.sv
hw/rtl/olrs_front.sv
hw/rtl/olrs_cmdq.sv
hw/rtl/olrs_back.sv
hw/rtl/overwriting_log_ring_snapshot_top.sv
tb/overwriting_log_ring_snapshot_top_test.sv
